// ----- src/bta_pkg.sv -----
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, constants and helpers for the binary to ascii formatter.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int DIGIT_SLOTS     = 5;
    localparam int CONV_STEPS      = 16;

    localparam logic [6:0] CHAR_ZERO     = 7'h30;
    localparam logic [6:0] CHAR_HEX_BASE = 7'h37;
    localparam logic [6:0] CHAR_MINUS    = 7'h2d;
    localparam logic [3:0] DEC_RADIX     = 4'd10;

    typedef enum logic [1:0] {
        ACT_SDEC     = 2'd0,
        ACT_UDEC     = 2'd1,
        ACT_HEX_BYTE = 2'd2,
        ACT_HEX_WORD = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_DEC      = 2'd0,
        KIND_HEX_BYTE = 2'd1,
        KIND_HEX_WORD = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic [15:0] data;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SIGN   = 3'd1,
        ST_CONV   = 3'd2,
        ST_DIGITS = 3'd3,
        ST_EMIT   = 3'd4
    } t_state;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        if (d >= DEC_RADIX) begin
            return CHAR_HEX_BASE + {3'b000, d};
        end
        return CHAR_ZERO + {3'b000, d};
    endfunction

    // double dabble correction of one bcd digit
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        if (d >= 4'd5) begin
            return d + 4'd3;
        end
        return d;
    endfunction

endpackage

// ----- src/bta_front.sv -----
// ----------------------------------------------------------------------------
// bta_front
// Takes commands, classifies the action and forms the magnitude.
// ----------------------------------------------------------------------------
module bta_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_action,
    input  logic [15:0]    i_value,
    output logic           o_busy,
    input  logic           i_full,
    output logic           o_push,
    output bta_pkg::t_item o_item
);
    import bta_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  accept;

    assign o_push = r_valid && !i_full;
    assign o_busy = r_valid && i_full;
    assign accept = i_start && !o_busy;
    assign o_item = r_item;

    always_comb begin
        n_item.neg  = 1'b0;
        n_item.data = i_value;
        case (t_action'(i_action))
            ACT_SDEC: begin
                n_item.kind = KIND_DEC;
                if (i_value[15]) begin
                    // 0x8000 negates to itself, which is the right magnitude
                    n_item.neg  = 1'b1;
                    n_item.data = ~i_value + 16'd1;
                end
            end
            ACT_UDEC:     n_item.kind = KIND_DEC;
            ACT_HEX_BYTE: n_item.kind = KIND_HEX_BYTE;
            ACT_HEX_WORD: n_item.kind = KIND_HEX_WORD;
            default:      n_item.kind = KIND_DEC;
        endcase
    end

    assign n_valid = accept || (r_valid && !o_push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- src/bta_queue.sv -----
// ----------------------------------------------------------------------------
// bta_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module bta_queue #(
    parameter int QUEUE_DEPTH = bta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bta_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output bta_pkg::t_item o_item
);
    import bta_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- src/bta_back.sv -----
// ----------------------------------------------------------------------------
// bta_back
// Converts one item to digits (double dabble for decimal) and emits the
// digits one per cycle, after a minus sign for a negative decimal value.
// ----------------------------------------------------------------------------
module bta_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  bta_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_strobe,
    output logic [6:0]     o_char_code,
    output logic           o_last_char
);
    import bta_pkg::*;

    localparam int SW = $clog2(CONV_STEPS);
    localparam logic [2:0] LAST_POS = 3'(DIGIT_SLOTS - 1);

    t_state      r_state, n_state;
    logic [15:0] r_bin;
    logic [19:0] r_bcd;
    logic [19:0] bcd_adj;
    logic [SW-1:0] r_step;
    logic [3:0]  r_digit [DIGIT_SLOTS];
    logic [2:0]  r_pos;
    logic        r_strobe, n_strobe;
    logic [6:0]  r_char, n_char;
    logic        r_last, n_last;

    assign o_pop       = (r_state == ST_IDLE) && !i_empty;
    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    always_comb begin
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            bcd_adj[4*i +: 4] = bcd_adjust(r_bcd[4*i +: 4]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_item.kind == KIND_DEC) begin
                        n_state = i_item.neg ? ST_SIGN : ST_CONV;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SIGN:   n_state = ST_CONV;
            ST_CONV:   if (r_step == SW'(CONV_STEPS - 1)) n_state = ST_DIGITS;
            ST_DIGITS: n_state = ST_EMIT;
            ST_EMIT:   if (r_pos == LAST_POS) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        n_strobe = 1'b0;
        n_char   = digit_char(r_digit[r_pos]);
        n_last   = 1'b0;
        case (r_state)
            ST_SIGN: begin
                n_strobe = 1'b1;
                n_char   = CHAR_MINUS;
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_last   = (r_pos == LAST_POS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_bin  <= i_item.data;
                    r_bcd  <= '0;
                    r_step <= '0;
                    // hex digits right-aligned in the store
                    r_digit[1] <= i_item.data[15:12];
                    r_digit[2] <= i_item.data[11:8];
                    r_digit[3] <= i_item.data[7:4];
                    r_digit[4] <= i_item.data[3:0];
                    r_pos      <= (i_item.kind == KIND_HEX_BYTE) ? 3'd3 : 3'd1;
                end
            end
            ST_CONV: begin
                r_bcd  <= {bcd_adj[18:0], r_bin[15]};
                r_bin  <= {r_bin[14:0], 1'b0};
                r_step <= r_step + SW'(1);
            end
            ST_DIGITS: begin
                for (int i = 0; i < DIGIT_SLOTS; i++) begin
                    r_digit[i] <= r_bcd[4*(DIGIT_SLOTS-1-i) +: 4];
                end
                // skip leading zeros, keep at least the units digit
                if (r_bcd[19:16] != 4'd0) begin
                    r_pos <= 3'd0;
                end else if (r_bcd[15:12] != 4'd0) begin
                    r_pos <= 3'd1;
                end else if (r_bcd[11:8] != 4'd0) begin
                    r_pos <= 3'd2;
                end else if (r_bcd[7:4] != 4'd0) begin
                    r_pos <= 3'd3;
                end else begin
                    r_pos <= 3'd4;
                end
            end
            ST_EMIT: begin
                r_pos <= r_pos + 3'd1;
            end
            default: ;
        endcase
    end

endmodule

// ----- src/binary_to_ascii_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// binary_to_ascii_formatter_unit
// Prints a 16-bit value as ascii text, one character per strobe.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low. Characters come
// out on o_char_code with o_strobe high for exactly one cycle each, the digits
// one per cycle, o_last_char marking the final one; receivers cannot stall them.
// Hex runs load the item and then print 2 or 4 characters. Decimal runs
// load the item, print a minus sign for a negative value, run the double
// dabble conversion, pick the leading digit, then print 1 to 5 digits.
// A queue of QUEUE_DEPTH items plus one front register lets commands arrive
// while a run is still printing; o_busy rises only when both are full.
// ----------------------------------------------------------------------------
module binary_to_ascii_formatter_unit #(
    parameter int QUEUE_DEPTH = bta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_value,
    output logic        o_busy,
    output logic        o_strobe,
    output logic [6:0]  o_char_code,
    output logic        o_last_char
);
    import bta_pkg::*;

    t_item front_item, queue_item;
    logic  push, pop, full, empty;

    bta_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_action),
        .i_value  (i_value),
        .o_busy   (o_busy),
        .i_full   (full),
        .o_push   (push),
        .o_item   (front_item)
    );

    bta_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    bta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule
